>>> src/lrusis_pkg.sv
package lrusis_pkg;

    // Field widths of one event and of one result.
    localparam int OP_W      = 2;
    localparam int SET_IDX_W = 11;
    localparam int WAY_IDX_W = 4;
    localparam int KIND_W    = 3;
    localparam int STAMP_W   = 64;

    // Event codes.
    localparam logic [OP_W-1:0] OP_VICTIM = 2'd0;
    localparam logic [OP_W-1:0] OP_FILL   = 2'd1;
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;

    // Access kinds that matter here.
    localparam logic [KIND_W-1:0] KIND_LOAD  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 3'd3;

    // One replacement event.
    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [SET_IDX_W-1:0] set_index;
        logic [WAY_IDX_W-1:0] way_index;
        logic [KIND_W-1:0]    access_kind;
        logic                 hit;
        logic [STAMP_W-1:0]   now_cycle;
    } req_t;

    // One result: the victim and the statistics after the event.
    typedef struct packed {
        logic [WAY_IDX_W-1:0] victim_way;
        logic [STAMP_W-1:0]   last_interval;
        logic [STAMP_W-1:0]   short_count;
        logic [STAMP_W-1:0]   access_count;
        logic [STAMP_W-1:0]   interval_total;
        logic [STAMP_W-1:0]   short_interval_total;
    } rsp_t;

endpackage

>>> src/lrusis_ram.sv
module lrusis_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/lru_replacement_with_set_interval_stats_unit.sv
// Timestamp LRU replacement for a set-associative cache with per-set reuse-interval
// statistics. Each event on req (victim query, fill or access update) gives exactly one
// beat on rsp carrying the victim way (zero for events other than a victim query) and
// the five statistics counters after the event. Events are handled one at a time. A
// fill or an update goes from acceptance through the EXEC state to the RESULT state,
// and the next event can be taken once its result is registered. A victim query adds
// the TREE states of a registered comparison tree that halves the way candidates at
// each level, before RESULT. When SETS is below 2048 and is 1 or not a power of two,
// the set index is reduced modulo SETS by a reciprocal multiplication in a REDUCE
// state, placed before the memory read of the event. A result
// that waits on rsp holds off the next result but not the next acceptance.
// Way stamps sit in one memory row per set and set last-access times in a second
// memory; after reset a clearing pass writes zero to both, one set per cycle, so req
// is not ready until the clearing pass is done.
module lru_replacement_with_set_interval_stats_unit
    import lrusis_pkg::*;
#(
    parameter int SETS = 2048,
    parameter int WAYS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WORK_W  = (SET_W > SET_IDX_W) ? SET_W : SET_IDX_W;
    localparam int WAY_W   = $clog2(WAYS);
    localparam int LEAVES  = 1 << WAY_W;
    localparam int LVL_W   = (WAY_W > 1) ? $clog2(WAY_W) : 1;
    localparam int ROW_W   = WAYS * STAMP_W;
    localparam bit MOD_NEEDED = (SETS < (1 << SET_IDX_W)) &&
                                (((SETS & (SETS - 1)) != 0) || (SETS == 1));

    // Reciprocal of SETS, exact for every set index that fits the field.
    localparam int RECIP_SH = 2 * SET_IDX_W;
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam int PROD_W   = SET_IDX_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << RECIP_SH) / SETS + 1);

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_REDUCE = 6'b000100,
        ST_EXEC   = 6'b001000,
        ST_TREE   = 6'b010000,
        ST_RESULT = 6'b100000
    } state_t;

    // Control state.
    state_t             state_reg, state_next;
    logic [SET_W-1:0]   clear_cnt_reg, clear_cnt_next;
    logic               rsp_valid_reg, rsp_valid_next;
    logic [STAMP_W-1:0] use_counter_reg, use_counter_next;
    logic [STAMP_W-1:0] last_interval_reg, last_interval_next;
    logic [STAMP_W-1:0] short_count_reg, short_count_next;
    logic [STAMP_W-1:0] access_count_reg, access_count_next;
    logic [STAMP_W-1:0] interval_total_reg, interval_total_next;
    logic [STAMP_W-1:0] short_total_reg, short_total_next;

    // Working registers of the event in flight.
    req_t               item_reg, item_next;
    logic [WORK_W-1:0]  set_work_reg, set_work_next;
    logic [LVL_W-1:0]   lvl_reg, lvl_next;
    logic [STAMP_W-1:0] iv_reg, iv_next;
    logic               counted_reg, counted_next;
    rsp_t               rsp_reg, rsp_next;
    logic [LEAVES-1:0][STAMP_W-1:0] cand_stamp_reg, cand_stamp_next;
    logic [LEAVES-1:0][WAY_W-1:0]   cand_way_reg, cand_way_next;
    logic [LEAVES-1:0]              cand_ok_reg, cand_ok_next;

    // Memory ports.
    logic               stamp_we, last_we, rd_en;
    logic [SET_W-1:0]   waddr, rd_addr;
    logic [ROW_W-1:0]   stamp_wdata, stamp_rdata;
    logic [STAMP_W-1:0] last_wdata, last_rdata;

    // Datapath helpers.
    logic [WAYS-1:0][STAMP_W-1:0]   row, row_new;
    logic [WORK_W-1:0]              req_set_ext, reduced;
    logic [PROD_W-1:0]              quot_prod;
    logic [SET_IDX_W-1:0]           quot;
    logic                           is_update_hit, do_count, do_stamp, way_ok;
    logic                           is_short;
    logic [LEAVES-1:0][STAMP_W-1:0] load_stamp, tree_stamp;
    logic [LEAVES-1:0][WAY_W-1:0]   load_way, tree_way;
    logic [LEAVES-1:0]              load_ok, tree_ok;

    lrusis_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (stamp_we),
        .waddr (waddr),
        .wdata (stamp_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (stamp_rdata)
    );

    lrusis_ram #(
        .WIDTH (STAMP_W),
        .DEPTH (SETS)
    ) u_last_ram (
        .clk   (clk),
        .we    (last_we),
        .waddr (waddr),
        .wdata (last_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (last_rdata)
    );

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Set index modulo SETS: quotient by reciprocal multiplication, then the remainder.
    assign req_set_ext = WORK_W'(req.set_index);
    assign quot_prod   = PROD_W'(set_work_reg[SET_IDX_W-1:0]) * PROD_W'(RECIP);
    assign quot        = quot_prod[RECIP_SH +: SET_IDX_W];
    assign reduced     = set_work_reg - WORK_W'(int'(quot) * SETS);

    // Decode of the event against the row just read.
    assign row           = stamp_rdata;
    assign is_update_hit = (item_reg.op == OP_UPDATE) && item_reg.hit;
    assign do_count      = is_update_hit && ((item_reg.access_kind == KIND_LOAD) ||
                                             (item_reg.access_kind == KIND_WRITE));
    assign way_ok        = int'(item_reg.way_index) < WAYS;
    assign do_stamp      = ((item_reg.op == OP_FILL) ||
                            (is_update_hit && (item_reg.access_kind != KIND_WRITE))) &&
                           way_ok;
    assign is_short      = counted_reg && (iv_reg < 64'(WAYS));

    // The accessed way takes the current use count.
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            row_new[w] = (int'(item_reg.way_index) == w) ? use_counter_reg : row[w];
        end
    end

    // Tree leaves from the row; padding leaves never win.
    always_comb
    begin
        for (int i = 0; i < LEAVES; i++)
        begin
            load_stamp[i] = '0;
            load_way[i]   = WAY_W'(i);
            load_ok[i]    = 1'b0;
            if (i < WAYS)
            begin
                load_stamp[i] = row[i];
                load_ok[i]    = 1'b1;
            end
        end
    end

    // One tree level: the right candidate wins only on a strictly smaller stamp.
    always_comb
    begin
        tree_stamp = cand_stamp_reg;
        tree_way   = cand_way_reg;
        tree_ok    = cand_ok_reg;
        for (int i = 0; i < LEAVES / 2; i++)
        begin
            if (cand_ok_reg[2*i+1] && (!cand_ok_reg[2*i] ||
                (cand_stamp_reg[2*i+1] < cand_stamp_reg[2*i])))
            begin
                tree_stamp[i] = cand_stamp_reg[2*i+1];
                tree_way[i]   = cand_way_reg[2*i+1];
                tree_ok[i]    = 1'b1;
            end
            else
            begin
                tree_stamp[i] = cand_stamp_reg[2*i];
                tree_way[i]   = cand_way_reg[2*i];
                tree_ok[i]    = cand_ok_reg[2*i];
            end
        end
    end

    // Sequencer and next-state logic.
    always_comb
    begin
        state_next          = state_reg;
        clear_cnt_next      = clear_cnt_reg;
        rsp_valid_next      = rsp_valid_reg;
        use_counter_next    = use_counter_reg;
        last_interval_next  = last_interval_reg;
        short_count_next    = short_count_reg;
        access_count_next   = access_count_reg;
        interval_total_next = interval_total_reg;
        short_total_next    = short_total_reg;
        item_next           = item_reg;
        set_work_next       = set_work_reg;
        lvl_next            = lvl_reg;
        iv_next             = iv_reg;
        counted_next        = counted_reg;
        rsp_next            = rsp_reg;
        cand_stamp_next     = cand_stamp_reg;
        cand_way_next       = cand_way_reg;
        cand_ok_next        = cand_ok_reg;
        stamp_we            = 1'b0;
        last_we             = 1'b0;
        waddr               = set_work_reg[SET_W-1:0];
        stamp_wdata         = row_new;
        last_wdata          = item_reg.now_cycle;
        rd_en               = 1'b0;
        rd_addr             = '0;

        // The waiting beat leaves once it is taken.
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                stamp_we    = 1'b1;
                last_we     = 1'b1;
                waddr       = clear_cnt_reg;
                stamp_wdata = '0;
                last_wdata  = '0;
                if (clear_cnt_reg == SET_W'(SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clear_cnt_next = clear_cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    item_next     = req;
                    set_work_next = req_set_ext;
                    if (MOD_NEEDED)
                    begin
                        state_next = ST_REDUCE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = req_set_ext[SET_W-1:0];
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_REDUCE:
            begin
                set_work_next = reduced;
                rd_en         = 1'b1;
                rd_addr       = reduced[SET_W-1:0];
                state_next    = ST_EXEC;
            end
            ST_EXEC:
            begin
                counted_next = do_count;
                iv_next      = item_reg.now_cycle - last_rdata;
                if (item_reg.op == OP_VICTIM)
                begin
                    cand_stamp_next = load_stamp;
                    cand_way_next   = load_way;
                    cand_ok_next    = load_ok;
                    lvl_next        = LVL_W'(WAY_W - 1);
                    state_next      = ST_TREE;
                end
                else
                begin
                    last_we  = do_count;
                    stamp_we = do_stamp;
                    if (do_stamp)
                    begin
                        use_counter_next = use_counter_reg + 1'b1;
                    end
                    state_next = ST_RESULT;
                end
            end
            ST_TREE:
            begin
                cand_stamp_next = tree_stamp;
                cand_way_next   = tree_way;
                cand_ok_next    = tree_ok;
                if (lvl_reg == '0)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    lvl_next = lvl_reg - 1'b1;
                end
            end
            ST_RESULT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    if (counted_reg)
                    begin
                        last_interval_next  = iv_reg;
                        access_count_next   = access_count_reg + 1'b1;
                        interval_total_next = interval_total_reg + iv_reg;
                    end
                    if (is_short)
                    begin
                        short_count_next = short_count_reg + 1'b1;
                        short_total_next = short_total_reg + iv_reg;
                    end
                    rsp_next.victim_way = (item_reg.op == OP_VICTIM) ?
                                          WAY_IDX_W'(cand_way_reg[0]) : '0;
                    rsp_next.last_interval        = last_interval_next;
                    rsp_next.short_count          = short_count_next;
                    rsp_next.access_count         = access_count_next;
                    rsp_next.interval_total       = interval_total_next;
                    rsp_next.short_interval_total = short_total_next;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_CLEAR;
            clear_cnt_reg      <= '0;
            rsp_valid_reg      <= 1'b0;
            use_counter_reg    <= '0;
            last_interval_reg  <= '0;
            short_count_reg    <= '0;
            access_count_reg   <= '0;
            interval_total_reg <= '0;
            short_total_reg    <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            clear_cnt_reg      <= clear_cnt_next;
            rsp_valid_reg      <= rsp_valid_next;
            use_counter_reg    <= use_counter_next;
            last_interval_reg  <= last_interval_next;
            short_count_reg    <= short_count_next;
            access_count_reg   <= access_count_next;
            interval_total_reg <= interval_total_next;
            short_total_reg    <= short_total_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        set_work_reg   <= set_work_next;
        lvl_reg        <= lvl_next;
        iv_reg         <= iv_next;
        counted_reg    <= counted_next;
        rsp_reg        <= rsp_next;
        cand_stamp_reg <= cand_stamp_next;
        cand_way_reg   <= cand_way_next;
        cand_ok_reg    <= cand_ok_next;
    end

endmodule

>>> src/lrusis_checker.sv
module lrusis_checker
    import lrusis_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    // A stalled result beat holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result beat changed while stalled");

    // Events are handled one at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
    else $error("second event taken while one is in flight");

    // The clearing pass holds off events right after reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !req_ready)
    else $error("event taken during the clearing pass");

    // Short intervals are counted among the counted ones.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.short_count <= rsp.access_count))
    else $error("short count exceeds the access count");

endmodule

bind lru_replacement_with_set_interval_stats_unit lrusis_checker u_lrusis_checker (.*);
